>>> rtl/core/nfa_pkg.sv
// Shared constants, codes and controller command types for the next-fit ID allocator.
`timescale 1ns / 1ps

package nfa_pkg;

    localparam int ID_COUNT    = 256;
    localparam int WORD_W      = 16;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int WORD_COUNT  = (ID_COUNT + WORD_W - 1) / WORD_W;
    localparam int WORD_IDX_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int ID_W        = WORD_IDX_W + BIT_W;
    localparam int RID_W       = 9;
    localparam int GRANT_W     = 8;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 16;

    typedef enum logic {
        KIND_ALLOC   = 1'b0,
        KIND_RELEASE = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_FIND   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic take;
        logic find;
        logic commit;
    } nfa_cmd_t;

endpackage

>>> rtl/core/nfa_ctrl.sv
// Controller state machine: request sequencing and result register handshake.
`timescale 1ns / 1ps

module nfa_ctrl
    import nfa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  kind_t    s_kind,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output nfa_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   commit_ok;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    // the result register is free, or is being emptied this cycle
    assign commit_ok = !out_valid_reg || m_tready;

    assign cmd.take   = s_tvalid && s_tready;
    assign cmd.find   = (state_reg == S_FIND);
    assign cmd.commit = (state_reg == S_COMMIT) && commit_ok;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.take) begin
                    state_next = (s_kind == KIND_RELEASE) ? S_COMMIT : S_FIND;
                end
            end
            S_FIND: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (commit_ok) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_rose_after_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("result valid rose without a commit");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |=> !s_tready)
        else $error("new item accepted while one is in progress");
`endif

endmodule

>>> rtl/core/nfa_dp.sv
// Datapath: used bitmap, search pointer, two-level free slot search and result register.
`timescale 1ns / 1ps

module nfa_dp
    import nfa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  nfa_cmd_t             cmd,
    input  kind_t                s_kind,
    input  logic [RID_W-1:0]     s_release_id,
    output logic [GRANT_W-1:0]   granted_id,
    output status_t              status
);

    logic [WORD_COUNT-1:0][WORD_W-1:0] used_reg;
    logic [ID_W-1:0]                   ptr_reg;

    // request and search stage registers
    kind_t                   kind_reg;
    logic [RID_W-1:0]        rid_reg;
    logic [WORD_COUNT-1:0]   word_free_reg;
    logic                    ge_free_reg;
    logic [WORD_IDX_W-1:0]   sel_word_reg;
    logic                    use_mask_reg;
    logic                    full_reg;

    logic [GRANT_W-1:0]      granted_reg;
    status_t                 status_reg;

    logic [WORD_COUNT-1:0][WORD_W-1:0] free_bits;
    logic [WORD_COUNT-1:0]             word_free;
    logic [WORD_IDX_W-1:0]             ptr_word;
    logic [BIT_W-1:0]                  ptr_bit;
    logic [WORD_W-1:0]                 ge_mask;

    logic [WORD_IDX_W-1:0]   start_word;
    logic [2*WORD_COUNT-1:0] word_dbl;
    logic [WORD_COUNT-1:0]   word_rot;
    logic [WORD_IDX_W:0]     word_off;
    logic                    word_any;
    logic [WORD_IDX_W:0]     word_sum;
    logic [WORD_IDX_W-1:0]   found_word;

    logic [WORD_W-1:0]       cand_bits;
    logic [BIT_W-1:0]        found_bit;
    logic [ID_W-1:0]         found_id;
    logic [ID_W-1:0]         next_ptr;
    logic                    rid_in_range;
    logic [ID_W-1:0]         rid_id;

    assign ptr_word = ptr_reg[ID_W-1:BIT_W];
    assign ptr_bit  = ptr_reg[BIT_W-1:0];

    // free bits; padding past the pool end counts as used
    always_comb begin
        for (int w = 0; w < WORD_COUNT; w++) begin
            for (int b = 0; b < WORD_W; b++) begin
                free_bits[w][b] = !used_reg[w][b] && ((w * WORD_W + b) < ID_COUNT);
            end
            word_free[w] = |free_bits[w];
        end
    end

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            ge_mask[b] = (BIT_W'(b) >= ptr_bit);
        end
    end

    // word level: rotate summaries to begin one word past the pointer word
    assign start_word = (ptr_word == WORD_IDX_W'(WORD_COUNT - 1)) ? '0 : ptr_word + 1'b1;
    assign word_dbl   = {word_free_reg, word_free_reg};
    assign word_rot   = word_dbl[start_word +: WORD_COUNT];

    always_comb begin
        word_off = '0;
        word_any = 1'b0;
        for (int i = WORD_COUNT - 1; i >= 0; i--) begin
            if (word_rot[i]) begin
                word_off = (WORD_IDX_W + 1)'(i);
                word_any = 1'b1;
            end
        end
    end

    assign word_sum   = {1'b0, start_word} + word_off;
    assign found_word = (word_sum >= (WORD_IDX_W + 1)'(WORD_COUNT))
                      ? WORD_IDX_W'(word_sum - (WORD_IDX_W + 1)'(WORD_COUNT))
                      : WORD_IDX_W'(word_sum);

    // bit level inside the chosen word
    assign cand_bits = free_bits[sel_word_reg] & (use_mask_reg ? ge_mask : '1);

    always_comb begin
        found_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (cand_bits[b]) begin
                found_bit = BIT_W'(b);
            end
        end
    end

    assign found_id     = {sel_word_reg, found_bit};
    assign next_ptr     = (found_id == ID_W'(ID_COUNT - 1)) ? '0 : found_id + 1'b1;
    assign rid_in_range = (32'(rid_reg) < ID_COUNT);
    assign rid_id       = ID_W'(rid_reg);

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            kind_reg      <= s_kind;
            rid_reg       <= s_release_id;
            word_free_reg <= word_free;
            ge_free_reg   <= |(free_bits[ptr_word] & ge_mask);
        end
        if (cmd.find) begin
            if (ge_free_reg) begin
                sel_word_reg <= ptr_word;
                use_mask_reg <= 1'b1;
                full_reg     <= 1'b0;
            end else begin
                sel_word_reg <= found_word;
                use_mask_reg <= 1'b0;
                full_reg     <= !word_any;
            end
        end
        if (cmd.commit) begin
            granted_reg <= '0;
            status_reg  <= ST_OK;
            if (kind_reg == KIND_ALLOC) begin
                if (full_reg) begin
                    status_reg <= ST_FULL;
                end else begin
                    granted_reg <= GRANT_W'(found_id);
                end
            end else if (!rid_in_range) begin
                status_reg <= ST_RANGE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            ptr_reg  <= '0;
        end else if (cmd.commit) begin
            if (kind_reg == KIND_ALLOC) begin
                if (!full_reg) begin
                    used_reg[sel_word_reg][found_bit] <= 1'b1;
                    ptr_reg                           <= next_ptr;
                end
            end else if (rid_in_range) begin
                used_reg[rid_id[ID_W-1:BIT_W]][rid_id[BIT_W-1:0]] <= 1'b0;
                ptr_reg                                           <= rid_id;
            end
        end
    end

    assign granted_id = granted_reg;
    assign status     = status_reg;

`ifndef NO_ASSERTIONS
    a_ptr_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ptr_reg) < ID_COUNT)
        else $error("search pointer beyond pool");

    a_grant_marks_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && kind_reg == KIND_ALLOC && !full_reg)
        |=> used_reg[$past(sel_word_reg)][$past(found_bit)])
        else $error("granted slot not marked used");
`endif

endmodule

>>> rtl/core/next_fit_id_allocator.sv
// Allocate passes a word search stage (S_FIND), then a bit search and commit
// stage (S_COMMIT) that registers the result; release goes straight to commit.
// Commit waits while the result register is full and not being read. One item
// in flight: next accept comes the cycle after the result is committed.
// Synchronous active-low reset clears the whole used bitmap and the search
// pointer together; no clearing pass is needed.
`timescale 1ns / 1ps

module next_fit_id_allocator
    import nfa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [8:0] release_id, rest zero
    input  logic                 s_tuser,   // [0] kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [GRANT_W-1:0]   m_tdata,   // [7:0] granted_id
    output logic [STATUS_W-1:0]  m_tuser    // [1:0] status
);

    nfa_cmd_t cmd;
    kind_t    s_kind;
    status_t  status;

    assign s_kind = kind_t'(s_tuser);

    nfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_kind),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    nfa_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_kind       (s_kind),
        .s_release_id (s_tdata[RID_W-1:0]),
        .granted_id   (m_tdata),
        .status       (status)
    );

    assign m_tuser = status;

endmodule
